// File: sv/wgm_pkg.sv
package wgm_pkg;

  // default buffer depths
  localparam int MAX_PATTERN_DEF = 256;
  localparam int MAX_SUBJECT_DEF = 256;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam int CHAR_W = 16;

  // item kinds on the input port
  localparam logic [1:0] KIND_PATTERN  = 2'd0;
  localparam logic [1:0] KIND_SUBJECT  = 2'd1;
  localparam logic [1:0] KIND_EVALUATE = 2'd2;

  // wildcard characters
  localparam logic [CHAR_W-1:0] CH_STAR = 16'h002A;
  localparam logic [CHAR_W-1:0] CH_ANY  = 16'h003F;

  typedef enum logic [1:0] {
    OP_PAT,
    OP_SUB,
    OP_EVAL
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] code;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_COMPARE,
    ST_TAIL_FETCH,
    ST_TAIL_COMPARE,
    ST_DONE
  } state_t;

endpackage

// File: sv/wgm_front.sv
module wgm_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [1:0]                         in_kind,
  input  logic [wgm_pkg::CHAR_W-1:0]         in_char_code,
  output logic                               cmd_valid,
  output wgm_pkg::cmd_t                      cmd,
  input  logic                               cmd_pop
);

  localparam int QAW = (wgm_pkg::QUEUE_DEPTH > 1) ? $clog2(wgm_pkg::QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(wgm_pkg::QUEUE_DEPTH + 1);

  wgm_pkg::cmd_t  queue_r [wgm_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  logic           accept;
  logic           keep;
  wgm_pkg::cmd_t  new_cmd;
  logic           do_wr;
  logic           do_rd;

  // classify: zero-character loads and unused kinds are dropped here
  always_comb begin
    keep         = 1'b0;
    new_cmd.op   = wgm_pkg::OP_EVAL;
    new_cmd.code = in_char_code;
    case (in_kind)
      wgm_pkg::KIND_PATTERN: begin
        new_cmd.op = wgm_pkg::OP_PAT;
        keep       = (in_char_code != '0);
      end
      wgm_pkg::KIND_SUBJECT: begin
        new_cmd.op = wgm_pkg::OP_SUB;
        keep       = (in_char_code != '0);
      end
      wgm_pkg::KIND_EVALUATE: begin
        new_cmd.op = wgm_pkg::OP_EVAL;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_full   = (count_r == QCW'(wgm_pkg::QUEUE_DEPTH));
  assign accept    = in_push && !in_full;
  assign do_wr     = accept && keep;
  assign cmd_valid = (count_r != '0);
  assign do_rd     = cmd_pop && cmd_valid;
  assign cmd       = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(wgm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(wgm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      queue_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// File: sv/wgm_engine.sv
module wgm_engine #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_SUBJECT = wgm_pkg::MAX_SUBJECT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  wgm_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_pop,
  output logic          res_valid,
  output logic          res_matched,
  output logic          res_overflow
);

  localparam int PAW = $clog2(MAX_PATTERN);
  localparam int PLW = $clog2(MAX_PATTERN + 1);
  localparam int SAW = $clog2(MAX_SUBJECT);
  localparam int SLW = $clog2(MAX_SUBJECT + 2);

  logic [wgm_pkg::CHAR_W-1:0] pat_mem [MAX_PATTERN];
  logic [wgm_pkg::CHAR_W-1:0] sub_mem [MAX_SUBJECT];

  wgm_pkg::state_t state_r, state_nxt;

  logic [PLW-1:0] plen_r, plen_nxt;
  logic [SLW-1:0] slen_r, slen_nxt;
  logic           ovf_r, ovf_nxt;
  logic [PLW-1:0] p_r, p_nxt;
  logic [PLW-1:0] star_p_r, star_p_nxt;
  logic [SLW-1:0] s_r, s_nxt;
  logic [SLW-1:0] retry_r, retry_nxt;
  logic           have_star_r, have_star_nxt;
  logic           match_r, match_nxt;
  logic           res_valid_r, res_valid_nxt;
  logic           res_matched_r, res_matched_nxt;
  logic           res_overflow_r, res_overflow_nxt;

  logic [wgm_pkg::CHAR_W-1:0] pdata_r;
  logic [wgm_pkg::CHAR_W-1:0] sdata_r;
  logic                       pvalid_r;

  logic                       pat_we;
  logic                       sub_we;
  logic                       out_free;
  logic                       empty_eval;
  logic [wgm_pkg::CHAR_W-1:0] w;
  logic                       is_star;
  logic                       hit;
  logic [PLW-1:0]             p_inc;

  assign cmd_pop    = (state_r == wgm_pkg::ST_IDLE) && cmd_valid;
  assign pat_we     = cmd_pop && (cmd.op == wgm_pkg::OP_PAT) && (plen_r < PLW'(MAX_PATTERN));
  assign sub_we     = cmd_pop && (cmd.op == wgm_pkg::OP_SUB) && (slen_r < SLW'(MAX_SUBJECT));
  assign out_free   = !res_valid_r || res_pop;
  assign empty_eval = (plen_r == '0) || (slen_r == '0);

  // past the end of the pattern reads as zero
  assign w       = pvalid_r ? pdata_r : '0;
  assign is_star = (w == wgm_pkg::CH_STAR);
  assign hit     = (w != '0) && ((w == sdata_r) || (w == wgm_pkg::CH_ANY));
  assign p_inc   = p_r + 1'b1;

  assign res_valid    = res_valid_r;
  assign res_matched  = res_matched_r;
  assign res_overflow = res_overflow_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wgm_pkg::ST_IDLE: begin
        if (cmd_valid && (cmd.op == wgm_pkg::OP_EVAL)) begin
          state_nxt = empty_eval ? wgm_pkg::ST_DONE : wgm_pkg::ST_FETCH;
        end
      end
      wgm_pkg::ST_FETCH: begin
        state_nxt = (s_r >= slen_r) ? wgm_pkg::ST_TAIL_FETCH : wgm_pkg::ST_COMPARE;
      end
      wgm_pkg::ST_COMPARE: begin
        if (is_star) begin
          state_nxt = (p_inc >= plen_r) ? wgm_pkg::ST_DONE : wgm_pkg::ST_FETCH;
        end else if (hit || have_star_r) begin
          state_nxt = wgm_pkg::ST_FETCH;
        end else begin
          state_nxt = wgm_pkg::ST_DONE;
        end
      end
      wgm_pkg::ST_TAIL_FETCH: begin
        state_nxt = wgm_pkg::ST_TAIL_COMPARE;
      end
      wgm_pkg::ST_TAIL_COMPARE: begin
        state_nxt = is_star ? wgm_pkg::ST_TAIL_FETCH : wgm_pkg::ST_DONE;
      end
      wgm_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = wgm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wgm_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    plen_nxt         = plen_r;
    slen_nxt         = slen_r;
    ovf_nxt          = ovf_r;
    p_nxt            = p_r;
    star_p_nxt       = star_p_r;
    s_nxt            = s_r;
    retry_nxt        = retry_r;
    have_star_nxt    = have_star_r;
    match_nxt        = match_r;
    res_valid_nxt    = res_valid_r && !res_pop;
    res_matched_nxt  = res_matched_r;
    res_overflow_nxt = res_overflow_r;
    case (state_r)
      wgm_pkg::ST_IDLE: begin
        if (cmd_pop) begin
          case (cmd.op)
            wgm_pkg::OP_PAT: begin
              if (pat_we) begin
                plen_nxt = plen_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            wgm_pkg::OP_SUB: begin
              if (sub_we) begin
                slen_nxt = slen_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            wgm_pkg::OP_EVAL: begin
              p_nxt         = '0;
              s_nxt         = '0;
              have_star_nxt = 1'b0;
              match_nxt     = 1'b1;
            end
            default: begin
              match_nxt = match_r;
            end
          endcase
        end
      end
      wgm_pkg::ST_COMPARE: begin
        if (is_star) begin
          p_nxt = p_inc;
          if (p_inc >= plen_r) begin
            match_nxt = 1'b1;
          end else begin
            star_p_nxt    = p_inc;
            retry_nxt     = s_r + 1'b1;
            have_star_nxt = 1'b1;
          end
        end else if (hit) begin
          p_nxt = p_inc;
          s_nxt = s_r + 1'b1;
        end else if (!have_star_r) begin
          match_nxt = 1'b0;
        end else begin
          p_nxt     = star_p_r;
          s_nxt     = retry_r;
          retry_nxt = retry_r + 1'b1;
        end
      end
      wgm_pkg::ST_TAIL_COMPARE: begin
        if (is_star) begin
          p_nxt = p_inc;
        end else begin
          match_nxt = (p_r >= plen_r);
        end
      end
      wgm_pkg::ST_DONE: begin
        if (out_free) begin
          res_valid_nxt    = 1'b1;
          res_matched_nxt  = match_r;
          res_overflow_nxt = ovf_r;
          plen_nxt         = '0;
          slen_nxt         = '0;
          ovf_nxt          = 1'b0;
        end
      end
      default: begin
        match_nxt = match_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wgm_pkg::ST_IDLE;
      plen_r      <= '0;
      slen_r      <= '0;
      ovf_r       <= 1'b0;
      have_star_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plen_r      <= plen_nxt;
      slen_r      <= slen_nxt;
      ovf_r       <= ovf_nxt;
      have_star_r <= have_star_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r            <= p_nxt;
    star_p_r       <= star_p_nxt;
    s_r            <= s_nxt;
    retry_r        <= retry_nxt;
    match_r        <= match_nxt;
    res_matched_r  <= res_matched_nxt;
    res_overflow_r <= res_overflow_nxt;
  end

  // character buffers, registered read at the current positions
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[plen_r[PAW-1:0]] <= cmd.code;
    end
    if (sub_we) begin
      sub_mem[slen_r[SAW-1:0]] <= cmd.code;
    end
    pdata_r  <= pat_mem[p_r[PAW-1:0]];
    sdata_r  <= sub_mem[s_r[SAW-1:0]];
    pvalid_r <= (p_r < plen_r);
  end

endmodule

// File: sv/wildcard_glob_matcher_top.sv
// wildcard glob matcher: push pattern characters (kind 0) and subject characters
// (kind 1) one 16-bit code per transaction, then an evaluate transaction (kind 2)
// yields exactly one result, matched and overflow, and clears both buffers and
// the overflow flag. '*' matches any run, '?' any single character; the match is
// greedy and backtracks to the latest star only. an empty pattern or subject
// reports a match. zero-code loads and kind 3 are dropped and give no result. a load
// into a full buffer is dropped and raises overflow for the next result.
// character loads are taken one per cycle while the command queue has room. an
// evaluation holds the back end for each compare step (one registered buffer
// read, one compare), where a step is a character match, a star or a backtrack
// to the latest star. a walk that runs off the end of the subject then reads and
// compares each trailing star and then the first non-star before the result is
// written. a walk may instead end early on a mismatch or on a final star, and an
// empty pattern or subject goes straight to writing the result.
// writing the result waits while the result register still holds an unpopped
// one. a two-entry command queue lets input transactions keep arriving
// meanwhile, and the result register lets the next command proceed while a
// result waits to be popped.
module wildcard_glob_matcher_top #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_SUBJECT = wgm_pkg::MAX_SUBJECT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input queue side
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_kind,
  input  logic [wgm_pkg::CHAR_W-1:0] in_char_code,
  // result queue side
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic                       out_matched,
  output logic                       out_overflow
);

  // commands between the classifying front end and the matching engine
  logic          cmd_valid;
  wgm_pkg::cmd_t cmd;
  logic          cmd_pop;
  logic          res_valid;

  // front end: classify each transaction, drop no-ops, queue the rest
  wgm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // back end: buffers, match sequencer and result register
  wgm_engine #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_SUBJECT (MAX_SUBJECT)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .res_pop      (out_pop),
    .res_valid    (res_valid),
    .res_matched  (out_matched),
    .res_overflow (out_overflow)
  );

  // result transaction is offered while the result register holds one
  assign out_empty = !res_valid;

endmodule

// File: tb/sv/wgm_checker.sv
module wgm_checker #(
  parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_SUBJECT = wgm_pkg::MAX_SUBJECT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic                       in_full,
  input  logic [1:0]                 in_kind,
  input  logic [wgm_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       out_empty,
  input  logic                       out_pop,
  input  logic                       out_matched,
  input  logic                       out_overflow,
  output int                         error_count,
  output int                         pending,
  output int                         checked_count,
  output int                         match_count,
  output int                         overflow_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import wgm_pkg::*;

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic [CHAR_W-1:0] pattern_chars [MAX_PATTERN];
  logic [CHAR_W-1:0] subject_chars [MAX_SUBJECT];
  int                pattern_len;
  int                subject_len;
  logic              overflow_flag;
  verdict_t          verdict_q [$];

  // zero stands for past the end
  function automatic logic [CHAR_W-1:0] pattern_char(int p);
    return (p < pattern_len) ? pattern_chars[p] : '0;
  endfunction

  function automatic logic [CHAR_W-1:0] subject_char(int s);
    return (s < subject_len) ? subject_chars[s] : '0;
  endfunction

  // greedy glob, backtracking to the latest star only
  function automatic logic glob_verdict();
    int                p;
    int                s;
    int                star_p;
    int                retry_s;
    logic              have_star;
    logic [CHAR_W-1:0] w;
    p = 0;
    s = 0;
    star_p = 0;
    retry_s = 0;
    have_star = 1'b0;
    if (pattern_len == 0 || subject_len == 0) return 1'b1;
    // literal prefix up to the first star
    while (s < subject_len && pattern_char(p) != CH_STAR) begin
      w = pattern_char(p);
      if (w != subject_char(s) && w != CH_ANY) return 1'b0;
      p++;
      s++;
    end
    while (s < subject_len) begin
      w = pattern_char(p);
      if (w == CH_STAR) begin
        p++;
        if (p >= pattern_len) return 1'b1;
        star_p = p;
        retry_s = s + 1;
        have_star = 1'b1;
      end else if (w != '0 && (w == subject_char(s) || w == CH_ANY)) begin
        p++;
        s++;
      end else begin
        if (!have_star) return 1'b0;
        p = star_p;
        s = retry_s;
        retry_s++;
      end
    end
    while (pattern_char(p) == CH_STAR) p++;
    return p >= pattern_len;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      pattern_len = 0;
      subject_len = 0;
      overflow_flag = 1'b0;
      verdict_q.delete();
      pending = 0;
    end else begin
      // result side first: a result never belongs to an evaluate taken at the same edge
      if (out_pop && !out_empty) begin
        if (verdict_q.size() == 0) begin
          $error("result with no evaluate outstanding: matched %0b overflow %0b",
                 out_matched, out_overflow);
          error_count++;
        end else begin
          want = verdict_q.pop_front();
          checked_count++;
          if (want.matched) match_count++;
          if (want.overflow) overflow_count++;
          if (out_matched !== want.matched) begin
            $error("matched: expected %0b, actual %0b", want.matched, out_matched);
            error_count++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, out_overflow);
            error_count++;
          end
        end
      end
      if (in_push && !in_full) begin
        case (in_kind)
          KIND_PATTERN: if (in_char_code != '0) begin
            if (pattern_len < MAX_PATTERN) begin
              pattern_chars[pattern_len] = in_char_code;
              pattern_len++;
            end else begin
              overflow_flag = 1'b1;
            end
          end
          KIND_SUBJECT: if (in_char_code != '0) begin
            if (subject_len < MAX_SUBJECT) begin
              subject_chars[subject_len] = in_char_code;
              subject_len++;
            end else begin
              overflow_flag = 1'b1;
            end
          end
          KIND_EVALUATE: begin
            want.matched = glob_verdict();
            want.overflow = overflow_flag;
            verdict_q.push_back(want);
            pattern_len = 0;
            subject_len = 0;
            overflow_flag = 1'b0;
          end
          default: ;
        endcase
      end
      pending = verdict_q.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wgm_pkg::*;

  // the fourth kind code, which the block must ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int STALL_LIMIT  = 20000;  // cycles with no transaction before giving up
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off to fill the block
  localparam int DRAIN_CYCLES = 600;    // settle time once nothing is outstanding
  // random part only; directed and long cases make up the rest of the run
  localparam int RANDOM_ITEMS = 600;

  localparam logic [CHAR_W-1:0] CH_A = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_B = 16'h0062;
  localparam logic [CHAR_W-1:0] CH_C = 16'h0063;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [1:0]        in_kind = KIND_PATTERN;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic              out_matched;
  logic              out_overflow;

  int error_count;
  int pending;
  int checked_count;
  int match_count;
  int overflow_count;

  // knobs and counters used by the sender, receiver and watchdog processes
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int hold_requests = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  wildcard_glob_matcher_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_matched  (out_matched),
    .out_overflow (out_overflow)
  );

  wgm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_kind        (in_kind),
    .in_char_code   (in_char_code),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_matched    (out_matched),
    .out_overflow   (out_overflow),
    .error_count    (error_count),
    .pending        (pending),
    .checked_count  (checked_count),
    .match_count    (match_count),
    .overflow_count (overflow_count)
  );

  // receiver: random stalls, plus a long hold-off whenever the stimulus asks for one
  initial begin : receiver
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= rst_n && ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: counts cycles in which no transaction happens on either side
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one transaction, with random idle cycles ahead of it, and wait until taken
  task automatic push_item(input logic [1:0] k, input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_kind <= k;
    in_char_code <= c;
    do @(posedge clk); while (in_full);
    // ignored transactions do not count towards the item budget
    if (k == KIND_EVALUATE || (k != KIND_UNUSED && c != '0)) items_sent++;
  endtask

  // drop push before any pause so the last transaction is not taken twice
  task automatic release_push();
    @(negedge clk);
    in_push <= 1'b0;
  endtask

  // char_code is don't-care on evaluate, so it carries random bits
  task automatic evaluate();
    push_item(KIND_EVALUATE, CHAR_W'($urandom_range(16'hFFFF)));
  endtask

  task automatic send_text(input logic [1:0] k, input string txt);
    for (int i = 0; i < txt.len(); i++) push_item(k, {8'h00, txt[i]});
  endtask

  // mostly a small alphabet so that matches happen, now and then any 16-bit code
  function automatic logic [CHAR_W-1:0] random_glyph(input bit wild);
    int r;
    r = $urandom_range(99);
    if (r < 35) return CH_A;
    if (r < 58) return CH_B;
    if (wild && r < 70) return CH_STAR;
    if (wild && r < 82) return CH_ANY;
    if (r < 90) return CH_C;
    return CHAR_W'($urandom_range(16'hFFFF));
  endfunction

  // one short pattern/subject pair, loads interleaved, then normally an evaluate
  task automatic send_glob_case();
    logic [CHAR_W-1:0] pat_q [$];
    logic [CHAR_W-1:0] sub_q [$];
    int                plen;
    int                n;
    plen = $urandom_range(8);
    repeat (plen) pat_q.push_back(random_glyph(1'b1));
    if ($urandom_range(1)) begin
      // subject expanded from the pattern, so most of these should match
      foreach (pat_q[i]) begin
        if (pat_q[i] == CH_STAR) begin
          repeat ($urandom_range(3)) sub_q.push_back(random_glyph(1'b0));
        end else if (pat_q[i] == CH_ANY) begin
          sub_q.push_back(random_glyph(1'b0));
        end else begin
          sub_q.push_back(pat_q[i]);
        end
      end
      // sometimes spoil one character
      if (sub_q.size() > 0 && $urandom_range(4) == 0)
        sub_q[$urandom_range(sub_q.size() - 1)] = random_glyph(1'b0);
    end else begin
      // free subject, wildcards occasionally present as plain characters
      n = $urandom_range(10);
      repeat (n) sub_q.push_back(random_glyph($urandom_range(9) == 0));
    end
    while (pat_q.size() + sub_q.size() > 0) begin
      // noise: zero codes and the unused kind
      if ($urandom_range(15) == 0) begin
        if ($urandom_range(1)) push_item(KIND_UNUSED, CHAR_W'($urandom_range(16'hFFFF)));
        else push_item($urandom_range(1) ? KIND_SUBJECT : KIND_PATTERN, '0);
      end
      if (sub_q.size() == 0 || (pat_q.size() > 0 && $urandom_range(1)))
        push_item(KIND_PATTERN, pat_q.pop_front());
      else
        push_item(KIND_SUBJECT, sub_q.pop_front());
    end
    // a broken sequence: no evaluate, so the next case appends to this one
    if ($urandom_range(15) != 0) evaluate();
  endtask

  // buffers loaded to and past their depth; without a star the walk is linear,
  // with a leading star the subject is uniform so backtracking stays short
  task automatic send_long_case(input int plen, input int slen, input bit lead_star);
    if (lead_star) push_item(KIND_PATTERN, CH_STAR);
    repeat (lead_star ? plen - 1 : plen)
      push_item(KIND_PATTERN, ($urandom_range(7) == 0) ? CH_ANY : CH_A);
    repeat (slen)
      push_item(KIND_SUBJECT, (!lead_star && $urandom_range(99) == 0) ? CH_B : CH_A);
    evaluate();
  endtask

  initial begin : stimulus
    int phase_end;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty strings, extreme codes, ignored transactions, wildcards
    evaluate();
    push_item(KIND_PATTERN, CH_A);
    evaluate();
    push_item(KIND_SUBJECT, 16'hFFFF);
    evaluate();
    push_item(KIND_PATTERN, CH_STAR);
    push_item(KIND_PATTERN, '0);
    push_item(KIND_UNUSED, 16'hFFFF);
    push_item(KIND_SUBJECT, 16'h0001);
    evaluate();
    send_text(KIND_PATTERN, "a?c");
    send_text(KIND_SUBJECT, "abc");
    evaluate();
    send_text(KIND_PATTERN, "a*b");
    send_text(KIND_SUBJECT, "axc");
    evaluate();

    // random part in four idling mixes: none, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      if (ph == 0) begin
        // pattern overflows, subject exactly full
        send_long_case(258, 256, 1'b0);
        // receiver holds off while evaluates keep coming, so the block backs up
        hold_requests++;
        repeat (12) begin
          push_item(KIND_PATTERN, random_glyph(1'b1));
          push_item(KIND_SUBJECT, random_glyph(1'b0));
          evaluate();
        end
        // sender pauses until every outstanding result has drained
        release_push();
        wait (pending == 0);
      end
      if (ph == 3) send_long_case(251, 260, 1'b1);
      phase_end = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < phase_end) send_glob_case();
      release_push();
      wait (pending == 0);
    end

    release_push();
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads and evaluates across four idle/stall mixes and a long hold-off",
             items_sent);
    $display("%0d results checked: %0d matches, %0d with overflow", checked_count,
             match_count, overflow_count);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
